// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the pulse grid fit search.
// Depends on nothing; included by modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/pgfs_pkg.sv -----
// Package of the pulse grid fit search: widths, register indexes, config and divider types.
// Depends on nothing.
`default_nettype none
package pgfs_pkg;
  localparam int MAX_EVENTS = 1024;
  localparam int POSITION_BITS = 24;
  localparam int ADDR_BITS = $clog2(MAX_EVENTS);
  localparam int CNT_BITS = $clog2(MAX_EVENTS + 1);
  localparam int CFG_IDX_BITS = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OFFSET_MIN    = 8'd0,
    REG_OFFSET_MAX    = 8'd1,
    REG_OFFSET_STEP   = 8'd2,
    REG_INTERVAL_MIN  = 8'd3,
    REG_INTERVAL_MAX  = 8'd4,
    REG_INTERVAL_STEP = 8'd5,
    REG_DEV_WEIGHT    = 8'd6,
    REG_SKIP_WEIGHT   = 8'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] offset_min;
    logic [15:0] offset_max;
    logic [15:0] offset_step;
    logic [15:0] interval_min;
    logic [15:0] interval_max;
    logic [15:0] interval_step;
    logic [15:0] deviation_weight;
    logic [15:0] skip_weight;
  } cfg_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quot;
    logic [15:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- hw/rtl/pgfs_if.sv -----
// Valid/ready channel interfaces of the pulse grid fit search.
// Depends on pgfs_pkg.
`default_nettype none
interface pgfs_in_if (input wire logic clk);
  logic                                 valid;
  logic                                 ready;
  logic [pgfs_pkg::POSITION_BITS-1:0]   event_position;
  logic [15:0]                          event_weight;
  logic                                 last_event;
  modport source (output valid, event_position, event_weight, last_event, input ready);
  modport sink (input valid, event_position, event_weight, last_event, output ready);
endinterface

interface pgfs_out_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [15:0] best_offset;
  logic [15:0] best_interval;
  modport source (output valid, best_offset, best_interval, input ready);
  modport sink (input valid, best_offset, best_interval, output ready);
endinterface

interface pgfs_cfg_if (input wire logic clk);
  logic                                valid;
  logic                                ready;
  logic [pgfs_pkg::CFG_IDX_BITS-1:0]   index;
  logic [15:0]                         data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pgfs_div.sv -----
// Radix-2 restoring divider: 33-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on pgfs_pkg.
`default_nettype none
module pgfs_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pgfs_pkg::div_req_t  req,
  output pgfs_pkg::div_rsp_t       rsp
);
  import pgfs_pkg::*;

  logic [32:0] q_r;
  logic [16:0] r_r;
  logic [15:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic [17:0] diff;

  assign trial = {r_r[15:0], q_r[32]};
  assign diff  = {1'b0, trial} - {2'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r    <= req.dividend;
        r_r    <= '0;
        d_r    <= req.divisor;
        cnt_r  <= 6'd33;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[17]) begin
          r_r <= diff[16:0];
          q_r <= {q_r[31:0], 1'b1};
        end else begin
          r_r <= trial;
          q_r <= {q_r[31:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r[15:0];
endmodule
`default_nettype wire

// ----- hw/rtl/pulse_grid_fit_search.sv -----
// Pulse grid fit search: events are stored one a cycle in a 1024-entry memory;
// the last event starts a search that reads every event once per candidate grid.
// For each event the search reads the memory, passes twice through the serial
// divider for the slot and the remainder, and does one multiply-accumulate; each
// candidate adds an offset check, five steps of cost arithmetic and a compare, and
// each interval an interval check. Input stalls during the search and
// while a finished result waits behind an unaccepted one. No clearing pass.
`default_nettype none
module pulse_grid_fit_search (
  input wire logic clk,
  input wire logic rst_n,
  pgfs_in_if.sink  in_ch,
  pgfs_out_if.source out_ch,
  pgfs_cfg_if.sink cfg_ch
);
  import pgfs_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_ICHK, S_OCHK, S_RD, S_RDW, S_DIVQ, S_DIVR, S_ACC,
    S_C1, S_C2, S_C3, S_C4, S_C5, S_CMP, S_OUT
  } state_t;

  state_t state_r;
  cfg_t   cfg_r;

  logic [POSITION_BITS-1:0] pos_mem [MAX_EVENTS];
  logic [15:0]              wgt_mem [MAX_EVENTS];
  logic [POSITION_BITS-1:0] pos_q_r;
  logic [15:0]              wgt_q_r;

  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] idx_r;
  logic [16:0] interval_r;
  logic [16:0] offset_r;
  logic [15:0] half_r;
  logic [63:0] best_cost_r;
  logic [15:0] best_off_r;
  logic [15:0] best_int_r;
  logic [63:0] dev_sum_r;
  logic [63:0] unused_r;
  logic signed [33:0] prev_slot_r;
  logic signed [33:0] rel_r;
  logic [63:0] t_a_r;
  logic [63:0] t_b_r;
  logic [53:0] b_lo_r;
  logic        sat_a_r;
  logic        sat_b_r;
  logic [63:0] cost_r;
  logic [15:0] dev_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pgfs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  logic in_xfer;
  logic cfg_xfer;
  logic out_load;
  logic [15:0] ostep;
  logic [15:0] istep;
  logic [16:0] obound;
  logic signed [33:0] rel_cur;
  logic [32:0] rel_abs;
  logic signed [33:0] slot;
  logic signed [34:0] gap;
  logic [31:0] rel_u32;
  logic [15:0] rem_div;
  logic [67:0] prod_a;
  logic [53:0] prod_hi;
  logic [71:0] prod_b;

  assign in_ch.ready  = (state_r == S_LOAD);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid;
  assign out_load = (state_r == S_OUT) && (!out_ch.valid || out_ch.ready);

  assign ostep  = (cfg_r.offset_step == 16'd0) ? 16'd1 : cfg_r.offset_step;
  assign istep  = (cfg_r.interval_step == 16'd0) ? 16'd1 : cfg_r.interval_step;
  assign obound = (cfg_r.offset_max == 16'd0) ? interval_r : {1'b0, cfg_r.offset_max};
  assign rel_cur = 34'(pos_q_r) + 34'(half_r) - 34'(offset_r);
  assign rel_abs = rel_cur[33] ? 33'(-rel_cur) : rel_cur[32:0];
  assign rel_u32 = rel_r[31:0];
  assign slot = rel_r[33] ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
  assign gap = 35'(slot) - 35'(prev_slot_r) - 35'sd1;
  assign rem_div = div_rsp.rem;
  assign prod_a  = 68'(t_a_r[56:0]) * 68'(count_r);
  assign prod_hi = 54'(t_b_r[35:0]) * 54'(unused_r[35:18]);
  assign prod_b  = 72'(b_lo_r) + {prod_hi, 18'd0};

  always_comb begin
    div_req = '0;
    div_req.divisor = interval_r[15:0];
    if (state_r == S_RDW) begin
      div_req.start = 1'b1;
      div_req.dividend = rel_abs;
    end else if (state_r == S_DIVQ && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.dividend = {1'b0, rel_u32};
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && count_r < CNT_BITS'(MAX_EVENTS)) begin
      pos_mem[count_r[ADDR_BITS-1:0]] <= in_ch.event_position;
      wgt_mem[count_r[ADDR_BITS-1:0]] <= in_ch.event_weight;
    end
    pos_q_r <= pos_mem[idx_r[ADDR_BITS-1:0]];
    wgt_q_r <= wgt_mem[idx_r[ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      out_ch.valid <= 1'b0;
      cfg_r <= '{offset_min: 16'd0, offset_max: 16'd0, offset_step: 16'd1,
                 interval_min: 16'd2, interval_max: 16'd64, interval_step: 16'd1,
                 deviation_weight: 16'd128, skip_weight: 16'd128};
    end else begin
      if (out_load) begin
        out_ch.best_offset <= best_off_r;
        out_ch.best_interval <= best_int_r;
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (cfg_xfer) begin
        case (cfg_ch.index)
          REG_OFFSET_MIN:    cfg_r.offset_min <= cfg_ch.data;
          REG_OFFSET_MAX:    cfg_r.offset_max <= cfg_ch.data;
          REG_OFFSET_STEP:   cfg_r.offset_step <= cfg_ch.data;
          REG_INTERVAL_MIN:  cfg_r.interval_min <= cfg_ch.data;
          REG_INTERVAL_MAX:  cfg_r.interval_max <= cfg_ch.data;
          REG_INTERVAL_STEP: cfg_r.interval_step <= cfg_ch.data;
          REG_DEV_WEIGHT:    cfg_r.deviation_weight <= cfg_ch.data;
          REG_SKIP_WEIGHT:   cfg_r.skip_weight <= cfg_ch.data;
          default: ;
        endcase
      end
      case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            if (count_r < CNT_BITS'(MAX_EVENTS)) count_r <= count_r + 1'b1;
            if (in_ch.last_event) state_r <= S_INIT;
          end
        end
        S_INIT: begin
          best_cost_r <= '1;
          best_off_r  <= '0;
          best_int_r  <= cfg_r.interval_min;
          interval_r  <= {1'b0, cfg_r.interval_min};
          state_r     <= S_ICHK;
        end
        S_ICHK: begin
          if (interval_r >= {1'b0, cfg_r.interval_max}) begin
            state_r <= S_OUT;
          end else if (interval_r == 17'd0) begin
            interval_r <= interval_r + {1'b0, istep};
          end else begin
            offset_r <= {1'b0, cfg_r.offset_min};
            half_r   <= {1'b0, interval_r[15:1]};
            state_r  <= S_OCHK;
          end
        end
        S_OCHK: begin
          if (offset_r >= obound) begin
            interval_r <= interval_r + {1'b0, istep};
            state_r <= S_ICHK;
          end else begin
            idx_r <= '0;
            dev_sum_r <= '0;
            unused_r <= '0;
            prev_slot_r <= '0;
            state_r <= (count_r == '0) ? S_C1 : S_RD;
          end
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          rel_r <= rel_cur;
          state_r <= S_DIVQ;
        end
        S_DIVQ: begin
          if (div_rsp.done) begin
            if (gap > 0) unused_r <= unused_r + 64'(gap);
            prev_slot_r <= slot;
            state_r <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_rsp.done) begin
            dev_r <= (rem_div >= half_r) ? rem_div - half_r : half_r - rem_div;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          dev_sum_r <= dev_sum_r + 64'(32'(wgt_q_r) * 32'(dev_r));
          idx_r <= idx_r + 1'b1;
          state_r <= (idx_r + 1'b1 == count_r) ? S_C1 : S_RD;
        end
        S_C1: begin
          // dev_sum < 2^42, weight 16 bits: no overflow here
          t_a_r <= 64'(58'(dev_sum_r[41:0]) * 58'(cfg_r.deviation_weight));
          t_b_r <= 64'(36'(21'(cfg_r.skip_weight) * 21'd20) * 36'(half_r));
          sat_a_r <= 1'b0;
          sat_b_r <= 1'b0;
          state_r <= S_C2;
        end
        S_C2: begin
          sat_a_r <= (prod_a[67:64] != 4'd0);
          t_a_r   <= prod_a[63:0];
          state_r <= S_C3;
        end
        S_C3: begin
          if (t_b_r != 64'd0 && unused_r[63:36] != 28'd0) sat_b_r <= 1'b1;
          b_lo_r <= 54'(t_b_r[35:0]) * 54'(unused_r[17:0]);
          state_r <= S_C4;
        end
        S_C4: begin
          if (prod_b[71:48] != 24'd0) sat_b_r <= 1'b1;
          t_b_r <= {prod_b[47:0], 16'd0};
          state_r <= S_C5;
        end
        S_C5: begin
          if (sat_a_r || sat_b_r || (t_a_r + t_b_r < t_a_r)) cost_r <= '1;
          else cost_r <= t_a_r + t_b_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (cost_r <= best_cost_r) begin
            best_cost_r <= cost_r;
            best_off_r <= offset_r[15:0];
            best_int_r <= interval_r[15:0];
          end
          offset_r <= offset_r + {1'b0, ostep};
          state_r <= S_OCHK;
        end
        S_OUT: begin
          if (out_load) begin
            count_r <= '0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_LOAD, !in_ch.ready)
  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_BITS'(MAX_EVENTS))
  `ASSERT_NEXT(a_out_after_search, clk, rst_n, state_r == S_OUT, out_ch.valid)
endmodule
`default_nettype wire
